// ----- hdl/brrqd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// brrqd_pkg
// shared constants and codes for the burst round-robin queue drainer
// ---------------------------------------------------------------------------
package brrqd_pkg;

	localparam int MAX_QUEUES_DEF           = 16;
	localparam int SWITCH_INTERVAL_LOG2_DEF = 10;

	localparam int CFG_W     = 5;   // queue_count register width
	localparam int SMASK_W   = 16;  // serial_mask field width
	localparam int QIDX_W    = 4;   // next_queue field width
	localparam int ROWS_W    = 32;  // rows_seen field width

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_POLL  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		POLL_ROW     = 2'd0,
		POLL_EMPTY   = 2'd1,
		POLL_DONE    = 2'd2,
		POLL_UNKNOWN = 2'd3
	} poll_status_t;

endpackage : brrqd_pkg
`default_nettype wire

// ----- hdl/burst_round_robin_queue_drainer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// burst_round_robin_queue_drainer
// picks which producer queue a consumer drains next, round robin with bursts
// ---------------------------------------------------------------------------
// The block takes one transaction per clock unless in_stall is high and
// returns exactly one result per transaction, held first in the input
// register, then in the result register. A
// start transaction opens a run over queue_count queues; each poll
// transaction reports what the current queue gave (row, temporarily empty,
// exhausted) and the result names the queue to poll next. The rate is set by
// the state loop: the active/serial masks, the current queue and the row
// counter are updated in the same cycle as the circular priority pick over
// MAX_QUEUES bits, so a following transaction sees the new state at once.
// queue_count is written through cfg_we/cfg_wdata and must only change while
// no transaction is in flight.
module burst_round_robin_queue_drainer
	import brrqd_pkg::*;
#(
	parameter int MAX_QUEUES           = MAX_QUEUES_DEF,
	parameter int SWITCH_INTERVAL_LOG2 = SWITCH_INTERVAL_LOG2_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// configuration
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,

	// request channel
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic                req_type,
	input  wire logic [SMASK_W-1:0]  serial_mask,
	input  wire logic [1:0]          poll_status,

	// result channel
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic                row_delivered,
	output      logic                bump_modify,
	output      logic                all_done,
	output      logic [QIDX_W-1:0]   next_queue,
	output      logic [ROWS_W-1:0]   rows_seen
);

	localparam int N   = MAX_QUEUES;
	localparam int QW  = (N > 1) ? $clog2(N) : 1;
	localparam int CW  = (N < SMASK_W) ? N : SMASK_W;
	localparam int SIL = SWITCH_INTERVAL_LOG2;

	// first set bit strictly after c going circularly, c itself if none
	function automatic logic [QW-1:0] pick_after(input logic [N-1:0] m,
		input logic [QW-1:0] c);
		logic [QW-1:0] hi;
		logic [QW-1:0] lo;
		logic          hi_f;
		logic          lo_f;
		hi   = '0;
		lo   = '0;
		hi_f = 1'b0;
		lo_f = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (m[i]) begin
				lo   = QW'(i);
				lo_f = 1'b1;
				if (i > int'(c)) begin
					hi   = QW'(i);
					hi_f = 1'b1;
				end
			end
		end
		return hi_f ? hi : (lo_f ? lo : c);
	endfunction

	// configuration register
	logic [CFG_W-1:0] queue_count_q;

	// input register
	logic               valid_s1;
	logic               req_type_s1;
	logic [SMASK_W-1:0] serial_mask_s1;
	logic [1:0]         poll_status_s1;

	// run state
	logic [N-1:0]      active_q;
	logic [N-1:0]      serial_q;
	logic [QW-1:0]     cur_q;
	logic              sf_q;        // serial-first mode
	logic [ROWS_W-1:0] row_cnt_q;

	// result register
	logic out_valid_q;
	logic row_delivered_q;
	logic bump_q;
	logic all_done_q;

	// next state
	logic [N-1:0]      active_d;
	logic [N-1:0]      serial_d;
	logic [QW-1:0]     cur_d;
	logic              sf_d;
	logic [ROWS_W-1:0] row_cnt_d;
	logic              row_delivered_d;
	logic              bump_d;
	logic              all_done_d;

	logic              out_free;
	logic              adv;         // input stage moves into the result stage
	logic [N-1:0]      smask_n;
	logic [N-1:0]      start_active;
	logic [N-1:0]      start_serial;
	logic [N-1:0]      left_mask;   // active queues after removing the current one
	logic [N-1:0]      left_serial;
	logic [QW+QIDX_W-1:0] cur_wide;

	// handshake: the result register frees up as soon as its transaction leaves
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_count_q <= CFG_W'(1);
		end else if (cfg_we) begin
			queue_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_type_s1    <= req_type;
			serial_mask_s1 <= serial_mask;
			poll_status_s1 <= poll_status;
		end
	end

	// start: queues below the clamped count, serial bits limited to them
	always_comb begin
		smask_n = '0;
		smask_n[CW-1:0] = serial_mask_s1[CW-1:0];
		for (int i = 0; i < N; i++) begin
			if (queue_count_q == '0) begin
				start_active[i] = (i == 0);
			end else begin
				start_active[i] = (i < int'(queue_count_q));
			end
		end
		start_serial = smask_n & start_active;
		left_mask    = active_q & ~(N'(1) << cur_q);
		left_serial  = left_mask & serial_q;
	end

	always_comb begin
		active_d        = active_q;
		serial_d        = serial_q;
		cur_d           = cur_q;
		sf_d            = sf_q;
		row_cnt_d       = row_cnt_q;
		row_delivered_d = 1'b0;
		bump_d          = 1'b0;
		all_done_d      = 1'b0;

		if (req_type_t'(req_type_s1) == REQ_START) begin
			active_d = start_active;
			serial_d = start_serial;
			sf_d     = |start_serial;
			cur_d    = '0;
			// highest serial queue becomes current
			for (int i = 0; i < N; i++) begin
				if (start_serial[i]) begin
					cur_d = QW'(i);
				end
			end
		end else if (active_q != '0) begin
			case (poll_status_t'(poll_status_s1))
				POLL_ROW: begin
					row_cnt_d       = row_cnt_q + ROWS_W'(1);
					row_delivered_d = 1'b1;
					bump_d          = !serial_q[cur_q];
					// burst quantum used up
					if (row_cnt_d[SIL-1:0] == '0 && !sf_q) begin
						cur_d = pick_after(active_q, cur_q);
					end
				end
				POLL_EMPTY: begin
					if (!sf_q) begin
						cur_d = pick_after(active_q, cur_q);
					end
				end
				POLL_DONE: begin
					active_d = left_mask;
					if (left_mask == '0) begin
						all_done_d = 1'b1;
						cur_d      = '0;
						sf_d       = 1'b0;
					end else if (sf_q && left_serial != '0) begin
						cur_d = pick_after(left_serial, cur_q);
					end else begin
						sf_d  = 1'b0;
						cur_d = pick_after(left_mask, cur_q);
					end
				end
				default: begin
					// unknown status leaves the run untouched
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			serial_q    <= '0;
			cur_q       <= '0;
			sf_q        <= 1'b0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				active_q  <= active_d;
				serial_q  <= serial_d;
				cur_q     <= cur_d;
				sf_q      <= sf_d;
				row_cnt_q <= row_cnt_d;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_delivered_q <= row_delivered_d;
			bump_q          <= bump_d;
			all_done_q      <= all_done_d;
		end
	end

	// state only moves together with the result register, so the current
	// queue and the row count always belong to the result on display
	assign cur_wide      = {{QIDX_W{1'b0}}, cur_q};
	assign out_valid     = out_valid_q;
	assign row_delivered = row_delivered_q;
	assign bump_modify   = bump_q;
	assign all_done      = all_done_q;
	assign next_queue    = cur_wide[QIDX_W-1:0];
	assign rows_seen     = row_cnt_q;

	// the run has ended whenever all_done is shown
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && all_done_q |-> active_q == '0)
		else $error("all_done shown while queues remain active");

	// serial-first mode needs a remaining serial queue
	a_sf_has_serial: assert property (@(posedge clk) disable iff (!arst_n)
		sf_q |-> (active_q & serial_q) != '0)
		else $error("serial-first mode without serial queue");

	// during a run the current queue is always one of the active ones
	a_cur_active: assert property (@(posedge clk) disable iff (!arst_n)
		active_q != '0 |-> active_q[cur_q])
		else $error("current queue not active");

	// a delivered row bumps the counter by exactly one
	a_row_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && row_delivered_d |=> row_cnt_q == $past(row_cnt_q) + ROWS_W'(1))
		else $error("row counter did not advance by one");

endmodule : burst_round_robin_queue_drainer
`default_nettype wire

// ----- dv/brrqd_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// brrqd_checker
// watches both channels of the queue drainer, predicts each pick and compares
// ---------------------------------------------------------------------------
module brrqd_checker
	import brrqd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic                req_type,
	input  wire logic [SMASK_W-1:0]  serial_mask,
	input  wire logic [1:0]          poll_status,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic                row_delivered,
	input  wire logic                bump_modify,
	input  wire logic                all_done,
	input  wire logic [QIDX_W-1:0]   next_queue,
	input  wire logic [ROWS_W-1:0]   rows_seen,
	output int                       fail_count,
	output int                       waiting
);

	localparam int NQ = MAX_QUEUES_DEF;
	localparam int SW = SWITCH_INTERVAL_LOG2_DEF;

	typedef struct packed {
		logic              row;
		logic              bump;
		logic              done;
		logic [QIDX_W-1:0] nxt;
		logic [ROWS_W-1:0] rows;
	} pick_t;

	logic [NQ-1:0]     live_q;
	logic [NQ-1:0]     serial_q;
	logic [QIDX_W-1:0] cur_q;
	logic [QIDX_W-1:0] prev_q;
	logic [ROWS_W-1:0] row_total;
	logic              serial_mode;
	logic [CFG_W-1:0]  queue_total;
	pick_t             pending_picks[$];
	pick_t             want_pick;

	// first live queue strictly after c, circularly
	function automatic logic [QIDX_W-1:0] hop_fwd(input logic [QIDX_W-1:0] c,
			input logic [NQ-1:0] m);
		int i;
		int q;
		for (i = 1; i <= NQ; i++) begin
			q = (int'(c) + i) % NQ;
			if (m[q])
				return QIDX_W'(q);
		end
		return c;
	endfunction

	// first live queue strictly before c, circularly
	function automatic logic [QIDX_W-1:0] hop_back(input logic [QIDX_W-1:0] c,
			input logic [NQ-1:0] m);
		int i;
		int q;
		for (i = 1; i <= NQ; i++) begin
			q = (int'(c) + NQ - (i % NQ)) % NQ;
			if (m[q])
				return QIDX_W'(q);
		end
		return c;
	endfunction

	function automatic void settle_on(input logic [QIDX_W-1:0] q);
		cur_q  = q;
		prev_q = hop_back(q, live_q);
	endfunction

	function automatic pick_t advance_drainer(input logic req,
			input logic [SMASK_W-1:0] smask, input logic [1:0] status);
		pick_t             r;
		int                n;
		int                i;
		int                k;
		logic [QIDX_W-1:0] q;
		logic [QIDX_W-1:0] cand;
		logic              found;
		r = '0;
		if (req_type_t'(req) == REQ_START) begin
			n = int'(queue_total);
			if (n < 1)
				n = 1;
			if (n > NQ)
				n = NQ;
			live_q = '0;
			for (i = 0; i < n; i++)
				live_q[i] = 1'b1;
			serial_q    = smask & live_q;
			serial_mode = 1'b0;
			cur_q       = '0;
			for (i = 0; i < n; i++)
				if (serial_q[i]) begin
					cur_q       = QIDX_W'(i);
					serial_mode = 1'b1;
				end
			settle_on(cur_q);
		end else if (live_q != '0) begin
			case (poll_status_t'(status))
				POLL_ROW: begin
					row_total = row_total + ROWS_W'(1);
					r.row     = 1'b1;
					r.bump    = !serial_q[cur_q];
					if (row_total[SW-1:0] == '0 && !serial_mode)
						settle_on(hop_fwd(cur_q, live_q));
				end
				POLL_EMPTY: begin
					if (!serial_mode)
						settle_on(hop_fwd(cur_q, live_q));
				end
				POLL_DONE: begin
					live_q[cur_q] = 1'b0;
					if (live_q == '0) begin
						r.done      = 1'b1;
						cur_q       = '0;
						prev_q      = '0;
						serial_mode = 1'b0;
					end else begin
						q = hop_fwd(cur_q, live_q);
						if (serial_mode) begin
							cand  = q;
							found = 1'b0;
							for (k = 0; k < NQ; k++) begin
								if (live_q[cand] && serial_q[cand]) begin
									found = 1'b1;
									break;
								end
								cand = hop_fwd(cand, live_q);
							end
							if (found)
								q = cand;
							else
								serial_mode = 1'b0;
						end
						settle_on(q);
					end
				end
				default: ;
			endcase
		end
		r.nxt  = cur_q;
		r.rows = row_total;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [ROWS_W-1:0] got,
			input logic [ROWS_W-1:0] want);
		$display("brrqd_checker: %s: got 0x%0h, wanted 0x%0h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      = '0;
			serial_q    = '0;
			cur_q       = '0;
			prev_q      = '0;
			row_total   = '0;
			serial_mode = 1'b0;
			queue_total = CFG_W'(1);
			pending_picks.delete();
			waiting     = 0;
		end else begin
			// results leave only after their transaction was accepted, so check first
			if (out_valid && !out_stall) begin
				if (pending_picks.size() == 0) begin
					flag_mismatch("result with no transaction pending", rows_seen, '0);
				end else begin
					want_pick = pending_picks.pop_front();
					if (row_delivered !== want_pick.row)
						flag_mismatch("row_delivered", ROWS_W'(row_delivered),
							ROWS_W'(want_pick.row));
					if (bump_modify !== want_pick.bump)
						flag_mismatch("bump_modify", ROWS_W'(bump_modify),
							ROWS_W'(want_pick.bump));
					if (all_done !== want_pick.done)
						flag_mismatch("all_done", ROWS_W'(all_done),
							ROWS_W'(want_pick.done));
					if (next_queue !== want_pick.nxt)
						flag_mismatch("next_queue", ROWS_W'(next_queue),
							ROWS_W'(want_pick.nxt));
					if (rows_seen !== want_pick.rows)
						flag_mismatch("rows_seen", rows_seen, want_pick.rows);
				end
			end
			if (cfg_we)
				queue_total = cfg_wdata;
			if (in_valid && !in_stall)
				pending_picks.push_back(advance_drainer(req_type, serial_mask, poll_status));
			waiting = pending_picks.size();
		end
	end

endmodule : brrqd_checker
`default_nettype wire

// ----- dv/tb_burst_round_robin_queue_drainer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tb_burst_round_robin_queue_drainer
// stimulus and verdict for the burst round-robin queue drainer
// ---------------------------------------------------------------------------
// A short directed run walks through polls with no run open, a single-queue
// run, serial-first runs, a serial set running dry, round robin on empties
// and a restart in the middle of a run. Random phases follow, each with its
// own queue_count (out-of-range values included), mostly well-formed runs
// (a start, then polls until every queue is exhausted) with random outcomes,
// plus restarts and stray polls. Both sides idle at random, one phase holds
// the result side off long enough to back the block up. The checker beside
// the block predicts and compares every result.
module tb_burst_round_robin_queue_drainer
	import brrqd_pkg::*;
();

	localparam int NQ              = MAX_QUEUES_DEF;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	req_type_t           req_type;
	logic [SMASK_W-1:0]  serial_mask;
	poll_status_t        poll_status;
	logic                out_valid;
	logic                out_stall;
	logic                row_delivered;
	logic                bump_modify;
	logic                all_done;
	logic [QIDX_W-1:0]   next_queue;
	logic [ROWS_W-1:0]   rows_seen;
	int                  fail_count;
	int                  waiting;

	// knobs shared between the sender and the receiver processes
	bit gaps_on;
	bit stalls_on;
	bit hold_off_go;
	bit hold_off_done;
	int cycle_count = 0;

	burst_round_robin_queue_drainer dut (.*);

	brrqd_checker drain_check (.*);

	// 20 time unit clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog: a stuck handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_burst_round_robin_queue_drainer: done, errors");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// serial sets: none, random, a single queue, or all of them
	function automatic logic [SMASK_W-1:0] pick_serial_mask();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return SMASK_W'($urandom);
			2:       return SMASK_W'(1) << $urandom_range(0, SMASK_W - 1);
			default: return '1;
		endcase
	endfunction

	// rows dominate so the row counter gets through the 1024-row switch point
	function automatic poll_status_t pick_poll();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72)
			return POLL_ROW;
		if (r < 84)
			return POLL_EMPTY;
		if (r < 97)
			return POLL_DONE;
		return POLL_UNKNOWN;
	endfunction

	// offer one transaction, hold it until accepted, then maybe idle a while
	task automatic offer(input req_type_t r, input logic [SMASK_W-1:0] m,
			input poll_status_t s);
		int g;
		in_valid    <= 1'b1;
		req_type    <= r;
		serial_mask <= m;
		poll_status <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		g = gaps_on ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// queue_count only moves while nothing is in flight
	task automatic drain_then_write(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		// two pipeline stages, a little margin on top
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one random phase: runs until goal starts and in-run polls with a known status were sent
	task automatic random_phase(input logic [CFG_W-1:0] v, input int goal,
			input bit gaps, input bit stalls, input bit hold);
		int           useful;
		int           left;
		int           span;
		poll_status_t s;
		drain_then_write(v);
		// queues in a run after clamping of the count
		span      = (v == 0) ? 1 : ((int'(v) > NQ) ? NQ : int'(v));
		gaps_on   = gaps;
		stalls_on = stalls;
		if (hold)
			hold_off_go = 1'b1;
		useful = 0;
		left   = 0;
		while (useful < goal) begin
			if (left == 0 && $urandom_range(0, 9) == 0) begin
				// stray poll once the bench's run is over, ignored unless the last phase left a run open
				offer(REQ_POLL, SMASK_W'($urandom), pick_poll());
			end else if (left == 0 || $urandom_range(0, 59) == 0) begin
				// new run, or a restart in the middle of one
				offer(REQ_START, pick_serial_mask(), poll_status_t'($urandom_range(0, 3)));
				left = span;
				useful++;
			end else begin
				s = pick_poll();
				offer(REQ_POLL, SMASK_W'($urandom), s);
				if (s == POLL_DONE)
					left--;
				if (s != POLL_UNKNOWN)
					useful++;
			end
		end
	endtask

	// result side: random stall runs, plus one long hold-off when asked for
	initial begin
		int  run_left;
		bit  stall_phase;
		out_stall   = 1'b0;
		run_left    = 0;
		stall_phase = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				// sender keeps offering, so the block fills and stalls its input
				hold_off_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					stall_phase = stalls_on && ($urandom_range(0, 2) == 0);
					run_left    = stall_phase ? gap_len() + 1 : $urandom_range(1, 12);
				end
				out_stall <= stall_phase;
				run_left--;
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_START;
		serial_mask   = '0;
		poll_status   = POLL_ROW;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		gaps_on       = 1'b1;
		stalls_on     = 1'b1;
		hold_off_go   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no run open yet: every outcome is ignored
		offer(REQ_POLL, '1, POLL_ROW);
		offer(REQ_POLL, '0, POLL_EMPTY);
		offer(REQ_POLL, '1, POLL_DONE);
		offer(REQ_POLL, '0, POLL_UNKNOWN);

		// reset count of one: a single serial queue, one row, then the run ends
		offer(REQ_START, '1, POLL_UNKNOWN);
		offer(REQ_POLL, '0, POLL_ROW);
		offer(REQ_POLL, '1, POLL_DONE);

		drain_then_write(CFG_W'(4));
		// serial bits beyond the count are dropped, queue 3 leads
		offer(REQ_START, '1, POLL_ROW);
		offer(REQ_POLL, '0, POLL_ROW);
		// serial-first: an empty does not move on
		offer(REQ_POLL, '1, POLL_EMPTY);
		offer(REQ_POLL, '0, POLL_UNKNOWN);
		// exhausting a serial queue hops to the next serial one
		offer(REQ_POLL, '1, POLL_DONE);

		// a lone serial queue runs dry, back to plain round robin
		offer(REQ_START, SMASK_W'(16'h0004), POLL_EMPTY);
		offer(REQ_POLL, '0, POLL_DONE);
		offer(REQ_POLL, '1, POLL_ROW);
		offer(REQ_POLL, '0, POLL_EMPTY);

		// restart mid-run with no serial queue, then exhaust everything
		offer(REQ_START, '0, POLL_DONE);
		offer(REQ_POLL, '1, POLL_ROW);
		offer(REQ_POLL, '0, POLL_EMPTY);
		offer(REQ_POLL, '1, POLL_DONE);
		offer(REQ_POLL, '0, POLL_DONE);
		offer(REQ_POLL, '1, POLL_DONE);
		offer(REQ_POLL, '0, POLL_DONE);
		// run closed again
		offer(REQ_POLL, '1, POLL_ROW);

		// random phases over counts in and out of range
		random_phase(CFG_W'(16), 250, 1'b1, 1'b1, 1'b0);
		random_phase(CFG_W'(1), 150, 1'b1, 1'b0, 1'b0);
		random_phase(CFG_W'(31), 250, 1'b1, 1'b1, 1'b1);
		random_phase(CFG_W'(0), 100, 1'b0, 1'b1, 1'b0);
		// no idling on either side
		random_phase(CFG_W'(17), 250, 1'b0, 1'b0, 1'b0);
		random_phase(CFG_W'($urandom_range(2, 15)), 300, 1'b1, 1'b1, 1'b0);
		random_phase(CFG_W'(8), 300, 1'b1, 1'b1, 1'b0);
		random_phase(CFG_W'($urandom_range(1, 16)), 400, 1'b1, 1'b1, 1'b0);

		// let every result come out, then keep watching for stray results
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("tb_burst_round_robin_queue_drainer: done, clean");
		else
			$display("tb_burst_round_robin_queue_drainer: done, errors");
		$finish;
	end

endmodule : tb_burst_round_robin_queue_drainer
`default_nettype wire

// ----- files.f -----
hdl/brrqd_pkg.sv
hdl/burst_round_robin_queue_drainer.sv
dv/brrqd_checker.sv
dv/tb_burst_round_robin_queue_drainer.sv
